// ===== design/htc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and color band tables of the terrain color core.
package htc_pkg;

    localparam int BAND_COUNT = 8;

    // Ratio divider: 32-bit divisor, 21 quotient bits (enough to see the 2^20 clamp).
    localparam int RATIO_DW = 32;
    localparam int RATIO_QW = 21;

    // Color divider: weight sum as divisor, 16-bit channel quotient.
    localparam int COLOR_DW = 20;
    localparam int COLOR_QW = 16;
    localparam int COLOR_NW = COLOR_DW + COLOR_QW;

    localparam logic [13:0] DRAW_MAX    = 14'd9999;
    localparam logic [15:0] DRAW_SPAN   = 16'd10000;
    localparam logic [20:0] RATIO_LIMIT = 21'd1048576;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [9:0]  THOUSAND    = 10'd1000;

    // floor(m / 1250) == (m * JITTER_RECIP) >> JITTER_SHIFT for every m below 2^30.
    localparam int          JITTER_SHIFT = 41;
    localparam logic [30:0] JITTER_RECIP = 31'((64'd2199023255552 + 64'd1249) / 64'd1250);

    // floor(x / half) == (x * BAND_RECIP) >> BAND_SHIFT for every x below 2^24.
    localparam int BAND_SHIFT = 32;

    typedef enum logic [1:0] {
        REG_HEIGHT_MIN   = 2'd0,
        REG_HEIGHT_MAX   = 2'd1,
        REG_JITTER_SCALE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] height;
        logic [13:0]        random_draw;
    } in_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } out_t;

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic        jneg;
        logic [29:0] jmag;
    } ratio_side_t;

    typedef struct packed {
        logic [COLOR_NW-1:0] num_red;
        logic [COLOR_NW-1:0] num_green;
        logic [COLOR_NW-1:0] num_blue;
        logic [COLOR_DW-1:0] divisor;
    } color_num_t;

    // Band order: snow, rock, dark forest, grass, bright grass, earth, sand, water.
    localparam logic [25:0] BAND_CENTER_Q [BAND_COUNT] = '{
        26'(925 * 65536), 26'(800 * 65536), 26'(675 * 65536), 26'(400 * 65536),
        26'(300 * 65536), 26'(400 * 65536), 26'(175 * 65536), 26'(75 * 65536)
    };

    localparam logic [23:0] BAND_HALF_Q [BAND_COUNT] = '{
        24'(75 * 65536), 24'(100 * 65536), 24'(125 * 65536), 24'(225 * 65536),
        24'(100 * 65536), 24'(50 * 65536), 24'(25 * 65536), 24'(75 * 65536)
    };

    localparam logic [27:0] BAND_RECIP [BAND_COUNT] = '{
        28'((64'd4294967296 + 64'd74) / 64'd75),
        28'((64'd4294967296 + 64'd99) / 64'd100),
        28'((64'd4294967296 + 64'd124) / 64'd125),
        28'((64'd4294967296 + 64'd224) / 64'd225),
        28'((64'd4294967296 + 64'd99) / 64'd100),
        28'((64'd4294967296 + 64'd49) / 64'd50),
        28'((64'd4294967296 + 64'd24) / 64'd25),
        28'((64'd4294967296 + 64'd74) / 64'd75)
    };

    localparam logic [7:0] BAND_RED [BAND_COUNT] = '{
        8'd220, 8'd94, 8'd13, 8'd55, 8'd34, 8'd109, 8'd237, 8'd94
    };
    localparam logic [7:0] BAND_GREEN [BAND_COUNT] = '{
        8'd220, 8'd71, 8'd55, 8'd170, 8'd156, 8'd61, 8'd200, 8'd97
    };
    localparam logic [7:0] BAND_BLUE [BAND_COUNT] = '{
        8'd220, 8'd64, 8'd13, 8'd80, 8'd13, 8'd39, 8'd85, 8'd186
    };

endpackage

// ===== design/htc_div_pipe.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
module htc_div_pipe #(
    parameter int DW = 32,
    parameter int QW = 21,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          pipe_en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_bits,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    // The word holds the dividend bits still to come in its top and the
    // quotient bits found so far in its bottom; it shifts by one per stage.
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] word_reg  [QW];
    logic [DW-1:0] div_reg   [QW];
    logic [SW-1:0] side_reg  [QW];
    logic          valid_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          v_in;
        logic [DW-1:0] r_in;
        logic [QW-1:0] w_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          fits;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] word_next;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = in_rem;
            assign w_in = in_bits;
            assign d_in = in_div;
            assign s_in = in_side;
        end else begin : g_rest
            assign v_in = valid_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign w_in = word_reg[k-1];
            assign d_in = div_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        assign trial     = {r_in, w_in[QW-1]};
        assign diff      = trial - {1'b0, d_in};
        assign fits      = trial >= {1'b0, d_in};
        assign rem_next  = fits ? diff[DW-1:0] : trial[DW-1:0];
        assign word_next = {w_in[QW-2:0], fits};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (pipe_en) begin
                valid_reg[k] <= v_in;
            end
            if (pipe_en) begin
                rem_reg[k]  <= rem_next;
                word_reg[k] <= word_next;
                div_reg[k]  <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = word_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ===== design/htc_front.sv =====
`timescale 1ns / 1ps
// Front stages: height offset, range, overflow test and jitter product.
module htc_front
    import htc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pipe_en,
    input  logic                in_valid,
    input  in_t                 in_data,
    input  logic signed [31:0]  height_min,
    input  logic signed [31:0]  height_max,
    input  logic [15:0]         jitter_scale,
    output logic                out_valid,
    output logic [RATIO_DW-1:0] out_rem,
    output logic [RATIO_QW-1:0] out_bits,
    output logic [RATIO_DW-1:0] out_div,
    output ratio_side_t         out_side
);

    logic signed [32:0] num_next;
    logic signed [32:0] den_next;
    logic [13:0]        draw_sat;
    logic signed [15:0] twice_next;

    logic               v1_reg;
    logic signed [32:0] num_reg;
    logic signed [32:0] den_reg;
    logic signed [15:0] twice_reg;

    logic               range_ok;
    logic               neg;
    logic [32:0]        mag_full;
    logic [31:0]        mag;
    logic               ovf;
    logic               tneg;
    logic [15:0]        tmag_full;
    logic [29:0]        jmag;
    logic               use_div;

    logic                v2_reg;
    logic [RATIO_DW-1:0] rem_reg;
    logic [RATIO_QW-1:0] bits_reg;
    logic [RATIO_DW-1:0] div_reg;
    ratio_side_t         side_reg;

    always_comb begin
        num_next   = $signed({in_data.height[31], in_data.height})
                   - $signed({height_min[31], height_min});
        den_next   = $signed({height_max[31], height_max})
                   - $signed({height_min[31], height_min});
        draw_sat   = (in_data.random_draw > DRAW_MAX) ? DRAW_MAX : in_data.random_draw;
        twice_next = $signed({1'b0, draw_sat, 1'b0}) - $signed(DRAW_SPAN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= in_valid;
        end
        if (pipe_en) begin
            num_reg   <= num_next;
            den_reg   <= den_next;
            twice_reg <= twice_next;
        end
    end

    // The quotient is known to exceed the clamp when |num| * 2^16 >= den * 2^21.
    always_comb begin
        range_ok  = !den_reg[32] && (den_reg != '0);
        neg       = num_reg[32];
        mag_full  = neg ? 33'(-num_reg) : 33'(num_reg);
        mag       = mag_full[31:0];
        ovf       = range_ok && ({5'b0, mag[31:5]} >= den_reg[31:0]);
        use_div   = range_ok && !ovf;
        tneg      = twice_reg[15];
        tmag_full = tneg ? 16'(-twice_reg) : 16'(twice_reg);
        jmag      = {16'b0, tmag_full[13:0]} * {14'b0, jitter_scale};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v2_reg <= v1_reg;
        end
        if (pipe_en) begin
            rem_reg       <= use_div ? {5'b0, mag[31:5]} : '0;
            bits_reg      <= use_div ? {mag[4:0], 16'b0} : '0;
            div_reg       <= range_ok ? den_reg[31:0] : 32'd1;
            side_reg.neg  <= neg;
            side_reg.ovf  <= ovf;
            side_reg.jneg <= tneg;
            side_reg.jmag <= jmag;
        end
    end

    assign out_valid = v2_reg;
    assign out_rem   = rem_reg;
    assign out_bits  = bits_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// ===== design/htc_blend.sv =====
`timescale 1ns / 1ps
// Blend stages: jittered value, band weights and color sums for the final divide.
module htc_blend
    import htc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pipe_en,
    input  logic                in_valid,
    input  logic [RATIO_QW-1:0] in_quo,
    input  ratio_side_t         in_side,
    output logic                out_valid,
    output color_num_t          out_num
);

    // Valid bits of the nine stages.
    logic [8:0] valid_reg;

    // Stage one: clamped ratio magnitude and jitter product.
    logic [20:0] rmag_next;
    logic [60:0] jprod_next;
    logic [20:0] rmag_reg;
    logic        neg_reg;
    logic        jneg_reg;
    logic [60:0] jprod_reg;

    // Stage two: signed ratio and jitter.
    logic signed [21:0] r_next;
    logic [19:0]        jm;
    logic signed [20:0] j_next;
    logic signed [21:0] r_reg;
    logic signed [20:0] j_reg;

    // Stage three: clamped value.
    logic signed [22:0] vsum;
    logic [16:0]        v_next;
    logic [16:0]        v_reg;

    // Stage four: value in thousandths.
    logic [26:0] vs_next;
    logic [26:0] vs_reg;

    // Stage five to seven: per band distance, scaled weight and color products.
    logic signed [27:0] dd     [BAND_COUNT];
    logic [26:0]        ad     [BAND_COUNT];
    logic [23:0]        x_next [BAND_COUNT];
    logic               act_next [BAND_COUNT];
    logic [23:0]        x_reg  [BAND_COUNT];
    logic               act5_reg [BAND_COUNT];
    logic [51:0]        p_reg  [BAND_COUNT];
    logic               act6_reg [BAND_COUNT];
    logic [16:0]        w_next [BAND_COUNT];
    logic [16:0]        w_reg  [BAND_COUNT];
    logic [24:0]        cr_reg [BAND_COUNT];
    logic [24:0]        cg_reg [BAND_COUNT];
    logic [24:0]        cb_reg [BAND_COUNT];

    // Stage eight and nine: sums, then rounded numerators.
    logic [19:0] s_next;
    logic [27:0] ar_next;
    logic [27:0] ag_next;
    logic [27:0] ab_next;
    logic [19:0] s_reg;
    logic [27:0] ar_reg;
    logic [27:0] ag_reg;
    logic [27:0] ab_reg;
    color_num_t  num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[7:0], in_valid};
        end
    end

    always_comb begin
        if (in_side.ovf || (in_quo > RATIO_LIMIT)) begin
            rmag_next = RATIO_LIMIT;
        end else begin
            rmag_next = in_quo;
        end
        jprod_next = {31'b0, in_side.jmag} * {30'b0, JITTER_RECIP};
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rmag_reg  <= rmag_next;
            neg_reg   <= in_side.neg;
            jneg_reg  <= in_side.jneg;
            jprod_reg <= jprod_next;
        end
    end

    always_comb begin
        r_next = neg_reg ? -$signed({1'b0, rmag_reg}) : $signed({1'b0, rmag_reg});
        jm     = jprod_reg[JITTER_SHIFT +: 20];
        j_next = jneg_reg ? -$signed({1'b0, jm}) : $signed({1'b0, jm});
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            r_reg <= r_next;
            j_reg <= j_next;
        end
    end

    always_comb begin
        vsum = 23'(r_reg) + 23'(j_reg);
        if (vsum < 0) begin
            v_next = '0;
        end else if (vsum > $signed({6'b0, ONE_Q16})) begin
            v_next = ONE_Q16;
        end else begin
            v_next = vsum[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            v_reg <= v_next;
        end
    end

    assign vs_next = {10'b0, v_reg} * {17'b0, THOUSAND};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            vs_reg <= vs_next;
        end
    end

    // A band is active only when the value lies strictly inside it.
    always_comb begin
        for (int i = 0; i < BAND_COUNT; i++) begin
            dd[i]       = $signed({1'b0, vs_reg}) - $signed({2'b0, BAND_CENTER_Q[i]});
            ad[i]       = dd[i][27] ? 27'(-dd[i]) : 27'(dd[i]);
            act_next[i] = ad[i] < {3'b0, BAND_HALF_Q[i]};
            x_next[i]   = BAND_HALF_Q[i] - ad[i][23:0];
        end
    end

    always_comb begin
        for (int i = 0; i < BAND_COUNT; i++) begin
            w_next[i] = act6_reg[i] ? p_reg[i][BAND_SHIFT +: 17] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < BAND_COUNT; i++) begin
                x_reg[i]    <= x_next[i];
                act5_reg[i] <= act_next[i];
                p_reg[i]    <= {28'b0, x_reg[i]} * {24'b0, BAND_RECIP[i]};
                act6_reg[i] <= act5_reg[i];
                w_reg[i]    <= w_next[i];
                cr_reg[i]   <= {8'b0, w_next[i]} * {17'b0, BAND_RED[i]};
                cg_reg[i]   <= {8'b0, w_next[i]} * {17'b0, BAND_GREEN[i]};
                cb_reg[i]   <= {8'b0, w_next[i]} * {17'b0, BAND_BLUE[i]};
            end
        end
    end

    always_comb begin
        s_next  = '0;
        ar_next = '0;
        ag_next = '0;
        ab_next = '0;
        for (int i = 0; i < BAND_COUNT; i++) begin
            s_next  = s_next + {3'b0, w_reg[i]};
            ar_next = ar_next + {3'b0, cr_reg[i]};
            ag_next = ag_next + {3'b0, cg_reg[i]};
            ab_next = ab_next + {3'b0, cb_reg[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s_reg  <= s_next;
            ar_reg <= ar_next;
            ag_reg <= ag_next;
            ab_reg <= ab_next;
        end
    end

    // Half the sum is added for rounding; an empty sum divides zero by one.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            num_reg.num_red   <= {ar_reg, 8'b0} + {17'b0, s_reg[19:1]};
            num_reg.num_green <= {ag_reg, 8'b0} + {17'b0, s_reg[19:1]};
            num_reg.num_blue  <= {ab_reg, 8'b0} + {17'b0, s_reg[19:1]};
            num_reg.divisor   <= (s_reg == '0) ? 20'd1 : s_reg;
        end
    end

    assign out_valid = valid_reg[8];
    assign out_num   = num_reg;

endmodule

// ===== design/height_to_terrain_color_core.sv =====
`timescale 1ns / 1ps
// Top level of the height to terrain color pipeline.
//
//  Port group     Direction  Handshake          Payload
//  s_*            in         s_valid / s_ready  s_data: height, random_draw
//  m_*            out        m_valid / m_ready  m_data: red, green, blue
//  cfg_*          in         cfg_wr_en          cfg_index, cfg_wdata
//
// One request enters per clock cycle while the pipeline advances; its color leaves
// through two front stages, 21 stages of the ratio divider (one quotient bit each),
// nine blend stages, 16 stages of the color dividers and the output register.
// The rate is one request per cycle while no stall on m_ready holds the pipeline.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// configuration registers with their defaults. When a result sits in the
// output register and m_ready is low, the whole pipeline holds in place, so
// nothing is dropped or repeated; s_ready follows that same enable.
module height_to_terrain_color_core
    import htc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic signed [31:0] height_min_reg;
    logic signed [31:0] height_max_reg;
    logic [15:0]        jitter_scale_reg;

    logic pipe_en;
    logic m_valid_reg;
    out_t m_data_reg;

    logic                fr_valid;
    logic [RATIO_DW-1:0] fr_rem;
    logic [RATIO_QW-1:0] fr_bits;
    logic [RATIO_DW-1:0] fr_div;
    ratio_side_t         fr_side;

    logic                rd_valid;
    logic [RATIO_QW-1:0] rd_quo;
    ratio_side_t         rd_side;

    logic                bl_valid;
    color_num_t          bl_num;

    logic                cd_valid;
    logic [COLOR_QW-1:0] q_red;
    logic [COLOR_QW-1:0] q_green;
    logic [COLOR_QW-1:0] q_blue;

    // The user must write configuration only while the pipeline is empty; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_min_reg   <= 32'sd0;
            height_max_reg   <= 32'sd65536;
            jitter_scale_reg <= 16'd4096;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HEIGHT_MIN:   height_min_reg   <= cfg_wdata;
                REG_HEIGHT_MAX:   height_max_reg   <= cfg_wdata;
                REG_JITTER_SCALE: jitter_scale_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or drains.
    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    htc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pipe_en      (pipe_en),
        .in_valid     (s_valid),
        .in_data      (s_data),
        .height_min   (height_min_reg),
        .height_max   (height_max_reg),
        .jitter_scale (jitter_scale_reg),
        .out_valid    (fr_valid),
        .out_rem      (fr_rem),
        .out_bits     (fr_bits),
        .out_div      (fr_div),
        .out_side     (fr_side)
    );

    // Ratio = |height - min| * 2^16 / (max - min); the jitter product rides along.
    htc_div_pipe #(
        .DW (RATIO_DW),
        .QW (RATIO_QW),
        .SW ($bits(ratio_side_t))
    ) u_ratio_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (fr_valid),
        .in_rem    (fr_rem),
        .in_bits   (fr_bits),
        .in_div    (fr_div),
        .in_side   (fr_side),
        .out_valid (rd_valid),
        .out_quo   (rd_quo),
        .out_side  (rd_side)
    );

    htc_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (rd_valid),
        .in_quo    (rd_quo),
        .in_side   (rd_side),
        .out_valid (bl_valid),
        .out_num   (bl_num)
    );

    // Three dividers in lockstep; the red one carries the valid bit.
    htc_div_pipe #(
        .DW (COLOR_DW),
        .QW (COLOR_QW),
        .SW (1)
    ) u_red_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (bl_valid),
        .in_rem    (bl_num.num_red[COLOR_NW-1:COLOR_QW]),
        .in_bits   (bl_num.num_red[COLOR_QW-1:0]),
        .in_div    (bl_num.divisor),
        .in_side   (1'b0),
        .out_valid (cd_valid),
        .out_quo   (q_red),
        .out_side  ()
    );

    htc_div_pipe #(
        .DW (COLOR_DW),
        .QW (COLOR_QW),
        .SW (1)
    ) u_green_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (bl_valid),
        .in_rem    (bl_num.num_green[COLOR_NW-1:COLOR_QW]),
        .in_bits   (bl_num.num_green[COLOR_QW-1:0]),
        .in_div    (bl_num.divisor),
        .in_side   (1'b0),
        .out_valid (),
        .out_quo   (q_green),
        .out_side  ()
    );

    htc_div_pipe #(
        .DW (COLOR_DW),
        .QW (COLOR_QW),
        .SW (1)
    ) u_blue_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (bl_valid),
        .in_rem    (bl_num.num_blue[COLOR_NW-1:COLOR_QW]),
        .in_bits   (bl_num.num_blue[COLOR_QW-1:0]),
        .in_div    (bl_num.divisor),
        .in_side   (1'b0),
        .out_valid (),
        .out_quo   (q_blue),
        .out_side  ()
    );

    // Output register: holds a finished color until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= cd_valid;
        end
        if (pipe_en) begin
            m_data_reg.red   <= q_red;
            m_data_reg.green <= q_green;
            m_data_reg.blue  <= q_blue;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the height to terrain color core.
module tb;
    import htc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    height_to_terrain_color_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Clock with a 4 ns period.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Shadow copy of the configuration registers, updated on every write.
    logic signed [31:0] shadow_min;
    logic signed [31:0] shadow_max;
    logic [15:0]        shadow_jitter;

    // Colors still owed by the block, oldest first.
    out_t pending_colors[$];

    int errors;
    int colors_seen;
    int requests_sent;
    int send_idle_pct;
    int recv_stall_pct;

    // Band table in thousandths, in the order snow to water.
    localparam int CTR [8]  = '{925, 800, 675, 400, 300, 400, 175, 75};
    localparam int HALF [8] = '{75, 100, 125, 225, 100, 50, 25, 75};
    localparam int CR [8]   = '{220, 94, 13, 55, 34, 109, 237, 94};
    localparam int CG [8]   = '{220, 71, 55, 170, 156, 61, 200, 97};
    localparam int CB [8]   = '{220, 64, 13, 80, 13, 39, 85, 186};

    // Computes the blended terrain color for one height and draw under the
    // current shadow configuration. The arithmetic is exact 64-bit integer
    // math, so the C-style truncation toward zero is what SystemVerilog
    // division gives on signed operands.
    function automatic out_t terrain_color(input in_t req);
        longint ratio, jit, level, scaled, cq, hq, gap, wgt;
        longint draw, wsum, acc_r, acc_g, acc_b;
        out_t   col;
        ratio = 0;
        draw = req.random_draw;
        if (draw > 9999) draw = 9999;
        if (shadow_max > shadow_min) begin
            ratio = (longint'(req.height) - longint'(shadow_min)) * 65536
                    / (longint'(shadow_max) - longint'(shadow_min));
            if (ratio < -1048576) ratio = -1048576;
            if (ratio > 1048576) ratio = 1048576;
        end
        jit = ((2 * draw - 10000) * longint'(shadow_jitter)) / 1250;
        level = ratio + jit;
        if (level < 0) level = 0;
        if (level > 65536) level = 65536;
        scaled = level * 1000;
        wsum = 0; acc_r = 0; acc_g = 0; acc_b = 0;
        for (int i = 0; i < 8; i++) begin
            cq = longint'(CTR[i]) * 65536;
            hq = longint'(HALF[i]) * 65536;
            gap = scaled - cq;
            if (gap < 0) gap = -gap;
            if (gap < hq) begin
                wgt = (hq - gap) / HALF[i];
                wsum += wgt;
                acc_r += wgt * CR[i] * 256;
                acc_g += wgt * CG[i] * 256;
                acc_b += wgt * CB[i] * 256;
            end
        end
        if (wsum == 0) begin
            col = '0;
        end else begin
            col.red   = 16'((acc_r + wsum / 2) / wsum);
            col.green = 16'((acc_g + wsum / 2) / wsum);
            col.blue  = 16'((acc_b + wsum / 2) / wsum);
        end
        return col;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s at color %0d: got %0d expected %0d",
                 what, colors_seen, got, want);
    endtask

    // Result monitor with a random stall on m_ready. Outputs are sampled at
    // the rising edge, before the nonblocking updates of that step land.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                out_t want;
                if (pending_colors.size() == 0) begin
                    report_mismatch("unexpected color", m_data.red, 0);
                end else begin
                    want = pending_colors.pop_front();
                    if (m_data.red !== want.red)
                        report_mismatch("red", m_data.red, want.red);
                    if (m_data.green !== want.green)
                        report_mismatch("green", m_data.green, want.green);
                    if (m_data.blue !== want.blue)
                        report_mismatch("blue", m_data.blue, want.blue);
                end
                colors_seen++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sends one request: optional random idle first, then valid held until
    // the block takes it. The expected color is queued at acceptance. Valid
    // stays high after acceptance so that back-to-back requests follow with
    // no gap; the next idle period or a drain lowers it.
    task automatic send_request(input logic signed [31:0] height, input logic [13:0] draw);
        in_t req;
        req.height = height;
        req.random_draw = draw;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_colors.push_back(terrain_color(req));
        requests_sent++;
    endtask

    // Waits until every owed color is back, then lets the pipe drain.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_HEIGHT_MIN:   shadow_min = value;
            REG_HEIGHT_MAX:   shadow_max = value;
            REG_JITTER_SCALE: shadow_jitter = value[15:0];
            default: ;
        endcase
    endtask

    // Directed requests at reset configuration and with edge settings.
    task automatic test_directed();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_request(32'sh7FFFFFFF, 14'd9999);
        send_request(32'sh80000000, 14'd0);
        send_request(32'sd0, 14'd5000);       // exactly zero, black
        send_request(32'sd65536, 14'd5000);   // exactly one, black
        send_request(32'sd26214, 14'd5000);   // grass, bright grass and earth overlap
        send_request(32'sd60620, 14'd5000);   // snow
        send_request(32'sd32768, 14'h3FFF);   // draw above 9999 saturates
        send_request(32'sd11469, 14'd2500);
        write_register(REG_JITTER_SCALE, 32'd0);
        send_request(32'sd52429, 14'd1234);
        send_request(32'sd4915, 14'd9999);
        write_register(REG_JITTER_SCALE, 32'hFFFF);
        send_request(32'sd32768, 14'd0);
        send_request(32'sd32768, 14'd9999);
        // Empty height range: ratio forced to zero.
        write_register(REG_HEIGHT_MAX, 32'sd0);
        send_request(32'sd12345, 14'd7000);
        write_register(REG_JITTER_SCALE, 32'd4096);
        send_request(32'sd12345, 14'd8000);
        // Widest range in both registers.
        write_register(REG_HEIGHT_MIN, 32'sh80000000);
        write_register(REG_HEIGHT_MAX, 32'sh7FFFFFFF);
        send_request(32'sh80000000, 14'd5000);
        send_request(32'sh7FFFFFFF, 14'd5000);
        send_request(32'sd0, 14'd5000);
        // Narrow range pushes the ratio into its clamp.
        write_register(REG_HEIGHT_MIN, 32'sd0);
        write_register(REG_HEIGHT_MAX, 32'sd1);
        send_request(32'sh7FFFFFFF, 14'd0);
        send_request(32'sh80000000, 14'd9999);
    endtask

    // Random requests in one configuration and one idling phase.
    task automatic test_random_phase(input int count, input int idle, input int stall);
        logic signed [31:0] height;
        longint span;
        send_idle_pct = idle; recv_stall_pct = stall;
        span = longint'(shadow_max) - longint'(shadow_min);
        for (int n = 0; n < count; n++) begin
            // Mostly heights inside the configured range, some fully random.
            if (span > 0 && $urandom_range(3) != 0)
                height = 32'(longint'(shadow_min) + longint'($urandom) % (span + 1));
            else
                height = $urandom;
            send_request(height, ($urandom_range(9) == 0) ? 14'($urandom)
                                                           : 14'($urandom_range(9999)));
        end
    endtask

    task automatic test_random();
        write_register(REG_HEIGHT_MIN, 32'sd0);
        write_register(REG_HEIGHT_MAX, 32'sd65536);
        write_register(REG_JITTER_SCALE, 32'd4096);
        test_random_phase(100, 0, 0);
        write_register(REG_HEIGHT_MIN, 32'hFFF00000);
        write_register(REG_HEIGHT_MAX, 32'h00A00000);
        write_register(REG_JITTER_SCALE, 32'($urandom_range(65535)));
        test_random_phase(100, 77, 0);
        write_register(REG_HEIGHT_MIN, $urandom);
        write_register(REG_HEIGHT_MAX, $urandom);
        write_register(REG_JITTER_SCALE, 32'($urandom_range(8191)));
        test_random_phase(100, 0, 77);
        write_register(REG_HEIGHT_MIN, 32'sd0);
        write_register(REG_HEIGHT_MAX, 32'sd65536);
        write_register(REG_JITTER_SCALE, 32'd1024);
        test_random_phase(100, 9, 9);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_HEIGHT_MIN;
        cfg_wdata = '0;
        errors = 0; colors_seen = 0; requests_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        shadow_min = 0; shadow_max = 65536; shadow_jitter = 4096;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        wait_drained();
        $display("Covered %0d requests and %0d colors over edge and random settings,",
                 requests_sent, colors_seen);
        $display("with streaming, sender idling, receiver stalls and mixed gaps.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== height_to_terrain_color_core.f =====
design/htc_pkg.sv
design/htc_div_pipe.sv
design/htc_front.sv
design/htc_blend.sv
design/height_to_terrain_color_core.sv
test/tb.sv
